### design/ssb_pkg.sv
// shared types and constants of the span sprite blitter
package ssb_pkg;

    // default frame geometry, header size and queue depth
    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int HEADER_BYTES      = 16;
    localparam int QUEUE_DEPTH_DEF   = 4;

    // field widths
    localparam int ADDR_W = 19;
    localparam int OX_W   = 10;
    localparam int OY_W   = 9;
    localparam int CFG_W  = 10;
    localparam int COL_W  = 17;
    localparam int ROW_W  = 16;

    // configuration register indexes
    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Y = 1'b1;

    // parse phase of the stream
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_SPANHDR = 2'd1,
        PH_PIXELS  = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    // input request
    typedef struct packed {
        logic [7:0] sprite_byte;
        logic       first_byte;
    } t_in_req;

    // output request
    typedef struct packed {
        logic              write_enable;
        logic [ADDR_W-1:0] write_address;
        logic [7:0]        pixel_value;
        logic              clipped;
        logic              sprite_done;
    } t_out_req;

    // classified byte handed from front to back
    typedef struct packed {
        logic             vis;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       pix;
        logic             done;
    } t_cmd;

endpackage

### design/span_sprite_blitter.sv
// top level of the span sprite blitter
//
//  channel   valid         stall         payload          direction
//  input     i_in_valid    o_in_stall    i_in_data        sprite byte in
//  output    o_out_valid   i_out_stall   o_out_data       pixel write out
//  config    i_cfg_we      -             i_cfg_index/data register write
//
// one sprite byte per cycle while the queue is not full, with exactly one result per byte
// each accepted byte reaches the output after passing its registers in order: queue slot, position stage,
// address stage
// the parser accepts bytes until the queue of QUEUE_DEPTH entries fills
// a stalled output holds the pipeline; the queue lets the parser run ahead
// synchronous active-low reset clears parser state, queue and pipeline valids
module span_sprite_blitter
    import ssb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_req          i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_req         o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    logic [OX_W-1:0] r_origin_x;
    logic [OY_W-1:0] r_origin_y;
    logic            accept;
    logic            q_full, q_valid, q_pop;
    t_cmd            f_cmd, q_cmd;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_y <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ORIGIN_X: r_origin_x <= i_cfg_data[OX_W-1:0];
                CFG_ORIGIN_Y: r_origin_y <= i_cfg_data[OY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = q_full;
    assign accept     = i_in_valid && !q_full;

    // parser
    ssb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_in_data),
        .o_cmd    (f_cmd)
    );

    // decoupling queue
    ssb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (f_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_cmd)
    );

    // address unit
    ssb_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_origin_x  (r_origin_x),
        .i_origin_y  (r_origin_y),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_pop   (q_pop),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data)
    );

endmodule

### design/ssb_front.sv
// stream parser: tracks header, span headers and pixels, classifies each byte
module ssb_front
    import ssb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  t_in_req i_req,
    output t_cmd    o_cmd
);

    t_phase      r_phase, n_phase, eff_phase;
    logic [3:0]  r_cnt, n_cnt, eff_cnt;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [15:0] r_row, n_row;
    logic [15:0] r_start, n_start;
    logic [15:0] r_length, n_length;
    logic [15:0] r_pos, n_pos;
    logic [15:0] row_next, pos_next;
    logic [COL_W-1:0] col;
    logic [7:0]  b;
    logic        hdr_end, row_end;
    t_cmd        cmd;

    // a first byte restarts the header parse
    assign eff_phase = i_req.first_byte ? PH_HEADER : r_phase;
    assign eff_cnt   = i_req.first_byte ? 4'd0 : r_cnt;
    assign b         = i_req.sprite_byte;
    assign row_next  = r_row + 16'd1;
    assign pos_next  = r_pos + 16'd1;
    assign col       = {1'b0, r_start} + {1'b0, r_pos};

    // field capture and byte classification
    always_comb begin
        n_cnt    = eff_cnt;
        n_width  = r_width;
        n_height = r_height;
        n_row    = r_row;
        n_start  = r_start;
        n_length = r_length;
        n_pos    = r_pos;
        hdr_end  = 1'b0;
        row_end  = 1'b0;
        cmd      = '0;
        case (eff_phase)
            PH_HEADER: begin
                if (eff_cnt == 4'd2) n_width[7:0] = b;
                else if (eff_cnt == 4'd3) n_width[15:8] = b;
                else if (eff_cnt == 4'd4) n_height[7:0] = b;
                else if (eff_cnt == 4'd5) n_height[15:8] = b;
                if ({1'b0, eff_cnt} + 5'd1 >= 5'(HEADER_BYTES)) begin
                    hdr_end = 1'b1;
                    n_row   = '0;
                    n_cnt   = '0;
                end else begin
                    n_cnt = eff_cnt + 4'd1;
                end
            end
            PH_SPANHDR: begin
                if (eff_cnt == 4'd0) n_start[7:0] = b;
                else if (eff_cnt == 4'd1) n_start[15:8] = b;
                else if (eff_cnt == 4'd2) n_length[7:0] = b;
                else n_length[15:8] = b;
                if (eff_cnt >= 4'd3) begin
                    n_cnt = '0;
                    n_pos = '0;
                    if (n_length == 16'd0) row_end = 1'b1;
                end else begin
                    n_cnt = eff_cnt + 4'd1;
                end
            end
            PH_PIXELS: begin
                cmd.vis = (b != 8'd0) && (col < {1'b0, r_width});
                cmd.col = col;
                cmd.row = r_row;
                cmd.pix = b;
                n_pos   = pos_next;
                if (pos_next >= r_length) row_end = 1'b1;
            end
            default: begin
            end
        endcase
        // end of a row
        if (row_end) begin
            n_row = row_next;
            n_cnt = '0;
            if (row_next >= r_height) cmd.done = 1'b1;
        end
        // empty sprite ends on the header
        if (hdr_end && n_height == 16'd0) cmd.done = 1'b1;
    end

    // next phase
    always_comb begin
        n_phase = eff_phase;
        case (eff_phase)
            PH_HEADER: begin
                if (hdr_end) n_phase = (n_height == 16'd0) ? PH_DONE : PH_SPANHDR;
            end
            PH_SPANHDR: begin
                if (eff_cnt >= 4'd3 && n_length != 16'd0) n_phase = PH_PIXELS;
            end
            default: begin
            end
        endcase
        if (row_end) n_phase = (row_next >= r_height) ? PH_DONE : PH_SPANHDR;
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_cnt    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_row    <= '0;
            r_start  <= '0;
            r_length <= '0;
            r_pos    <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_width  <= n_width;
            r_height <= n_height;
            r_row    <= n_row;
            r_start  <= n_start;
            r_length <= n_length;
            r_pos    <= n_pos;
        end
    end

    assign o_cmd = cmd;

endmodule

### design/ssb_queue.sv
// small fifo of classified bytes between parser and address unit
module ssb_queue
    import ssb_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;
    assign o_data  = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

endmodule

### design/ssb_back.sv
// address unit: screen position, frame clip, linear address, output register
module ssb_back
    import ssb_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [OX_W-1:0] i_origin_x,
    input  logic [OY_W-1:0] i_origin_y,
    input  logic            i_cmd_valid,
    input  t_cmd            i_cmd,
    output logic            o_cmd_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output t_out_req        o_data
);

    localparam int SX_W   = COL_W + 1;
    localparam int SY_W   = ROW_W + 1;
    localparam int SW_W   = $clog2(SCREEN_WIDTH + 1);
    localparam int PROD_W = SY_W + SW_W + 1;

    // stage a: screen position
    logic            r_a_valid;
    logic            r_a_vis, r_a_in, r_a_done;
    logic [7:0]      r_a_pix;
    logic [SX_W-1:0] r_a_sx;
    logic [SY_W-1:0] r_a_sy;
    logic [SX_W-1:0] sx;
    logic [SY_W-1:0] sy;

    // stage b: output register
    logic            r_b_valid;
    t_out_req        r_b_data, n_b_data;
    logic [PROD_W-1:0] addr_full;

    logic b_take, a_take;

    assign b_take    = !r_b_valid || !i_stall;
    assign a_take    = !r_a_valid || b_take;
    assign o_cmd_pop = i_cmd_valid && a_take;

    assign sx = SX_W'(i_origin_x) + SX_W'(i_cmd.col);
    assign sy = SY_W'(i_origin_y) + SY_W'(i_cmd.row);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_take) begin
            r_a_valid <= i_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_take) begin
            r_a_vis  <= i_cmd.vis;
            r_a_in   <= (sx < SX_W'(SCREEN_WIDTH)) && (sy < SY_W'(SCREEN_HEIGHT));
            r_a_done <= i_cmd.done;
            r_a_pix  <= i_cmd.pix;
            r_a_sx   <= sx;
            r_a_sy   <= sy;
        end
    end

    // linear address and result fields
    always_comb begin
        addr_full = PROD_W'(r_a_sy) * PROD_W'(SCREEN_WIDTH) + PROD_W'(r_a_sx);
        n_b_data  = '0;
        n_b_data.sprite_done = r_a_done;
        if (r_a_vis) begin
            if (r_a_in) begin
                n_b_data.write_enable  = 1'b1;
                n_b_data.write_address = addr_full[ADDR_W-1:0];
                n_b_data.pixel_value   = r_a_pix;
            end else begin
                n_b_data.clipped = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_take) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_take) r_b_data <= n_b_data;
    end

    assign o_valid = r_b_valid;
    assign o_data  = r_b_data;

endmodule

### design/ssb_checker.sv
// port-level checks of the span sprite blitter and their binding
module ssb_checker
    import ssb_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input t_in_req          i_in_data,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input t_out_req         o_out_data
);

    // a stalled input request stays offered and unchanged
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("input request changed under stall");

    // a stalled request stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output request dropped under stall");

    // a written pixel is never transparent
    a_pix_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.write_enable |-> o_out_data.pixel_value != 8'd0)
        else $error("transparent pixel written");

    // a pixel is never both written and clipped
    a_we_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.write_enable && o_out_data.clipped))
        else $error("pixel both written and clipped");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind span_sprite_blitter ssb_checker u_ssb_checker (.*);
